### src/gnzm_pkg.sv
// ----------------------------------------------------------------------------
// gnzm_pkg
// Shared codes and controller/datapath interface types for the greedy
// nearest-z matcher.
// ----------------------------------------------------------------------------
package gnzm_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned INDEX_W  = 6;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                count_clear;
        logic                load_en;
        logic                scan_init;
        logic                scan_issue;
        logic                mark;
        logic                out_load;
        logic                out_match;
        logic [STATUS_W-1:0] out_code;
    } gnzm_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic empty;
        logic scan_last;
        logic pipe_empty;
        logic found;
    } gnzm_status_t;

endpackage

### src/greedy_nearest_z_matcher.sv
// Clear, load, unused and empty-store query go from accept through RESP to the result beat;
// other queries take one read per entry, the rd_ and d_ compare registers, decide, then output.
// Throughput: one beat at a time; the next beat is taken once the result is in the
// output register, which may still be waiting for m_ready.
// Reset: synchronous active-low aresetn clears entry count and valid flags; used flags
// and store contents are rewritten on load and need no clearing pass.
// ----------------------------------------------------------------------------
// greedy_nearest_z_matcher
// Matches query z positions to the closest unused stored reference entry.
// ----------------------------------------------------------------------------
module greedy_nearest_z_matcher
    import gnzm_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 64,
    parameter int unsigned Z_BITS       = 20
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [CMD_W-1:0]          s_command,
    input  logic signed [Z_BITS-1:0]  s_z_um,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic [INDEX_W-1:0]        m_match_index,
    output logic [Z_BITS-1:0]         m_distance
);

    gnzm_cmd_t    cmd;
    gnzm_status_t status;

    gnzm_controller u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .status    (status)
    );

    gnzm_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .Z_BITS       (Z_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .z_in         (s_z_um),
        .res_status   (m_status),
        .res_index    (m_match_index),
        .res_distance (m_distance)
    );

endmodule

### src/gnzm_datapath.sv
// ----------------------------------------------------------------------------
// gnzm_datapath
// Reference store, entry count, scan pipeline with running minimum, and the
// result payload registers.
// ----------------------------------------------------------------------------
module gnzm_datapath
    import gnzm_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 64,
    parameter int unsigned Z_BITS       = 20
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  gnzm_cmd_t                  cmd,
    output gnzm_status_t               status,
    input  logic signed [Z_BITS-1:0]   z_in,
    output logic [STATUS_W-1:0]        res_status,
    output logic [INDEX_W-1:0]         res_index,
    output logic [Z_BITS-1:0]          res_distance
);

    localparam int unsigned IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);

    logic [Z_BITS-1:0] z_mem [MAX_VERTICES];
    logic              used_mem [MAX_VERTICES];

    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  addr_reg;
    logic [Z_BITS-1:0] query_reg;

    logic [Z_BITS-1:0] rd_z_reg;
    logic              rd_used_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              rd_valid_reg;

    logic [Z_BITS-1:0] d_dist_reg;
    logic              d_used_reg;
    logic [IDX_W-1:0]  d_idx_reg;
    logic              d_valid_reg;

    logic [Z_BITS-1:0] best_dist_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic              found_reg;

    logic [STATUS_W-1:0] out_status_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [Z_BITS-1:0]   out_distance_reg;

    logic [Z_BITS:0]         diff;
    logic [Z_BITS:0]         diff_abs;
    logic [IDX_W+INDEX_W-1:0] best_idx_wide;
    logic                    take_entry;

    assign status.full       = (count_reg == CNT_W'(MAX_VERTICES));
    assign status.empty      = (count_reg == '0);
    assign status.scan_last  = (CNT_W'(addr_reg) == CNT_W'(count_reg - 1'b1));
    assign status.pipe_empty = !rd_valid_reg && !d_valid_reg;
    assign status.found      = found_reg;

    assign diff     = {rd_z_reg[Z_BITS-1], rd_z_reg} - {query_reg[Z_BITS-1], query_reg};
    assign diff_abs = diff[Z_BITS] ? (~diff + 1'b1) : diff;

    assign take_entry    = d_valid_reg && !d_used_reg && (!found_reg || d_dist_reg < best_dist_reg);
    assign best_idx_wide = {{INDEX_W{1'b0}}, best_idx_reg};

    // Store: one write port each, read on scan issue
    always_ff @(posedge aclk) begin
        if (cmd.load_en) begin
            z_mem[count_reg[IDX_W-1:0]] <= z_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_en) begin
            used_mem[count_reg[IDX_W-1:0]] <= 1'b0;
        end else if (cmd.mark) begin
            used_mem[best_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_issue) begin
            rd_z_reg    <= z_mem[addr_reg];
            rd_used_reg <= used_mem[addr_reg];
            rd_idx_reg  <= addr_reg;
        end
        d_dist_reg <= diff_abs[Z_BITS-1:0];
        d_used_reg <= rd_used_reg;
        d_idx_reg  <= rd_idx_reg;
        if (cmd.scan_init) begin
            query_reg <= z_in;
        end
        if (take_entry) begin
            best_dist_reg <= d_dist_reg;
            best_idx_reg  <= d_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
            d_valid_reg  <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            if (cmd.count_clear) begin
                count_reg <= '0;
            end else if (cmd.load_en) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.scan_init) begin
                addr_reg <= '0;
            end else if (cmd.scan_issue) begin
                addr_reg <= addr_reg + 1'b1;
            end
            rd_valid_reg <= cmd.scan_issue;
            d_valid_reg  <= rd_valid_reg;
            if (cmd.scan_init) begin
                found_reg <= 1'b0;
            end else if (take_entry) begin
                found_reg <= 1'b1;
            end
        end
    end

    // Result payload; zero index and distance unless a match
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg   <= cmd.out_code;
            out_index_reg    <= cmd.out_match ? best_idx_wide[INDEX_W-1:0] : '0;
            out_distance_reg <= cmd.out_match ? best_dist_reg : '0;
        end
    end

    assign res_status   = out_status_reg;
    assign res_index    = out_index_reg;
    assign res_distance = out_distance_reg;

endmodule

### src/gnzm_controller.sv
// ----------------------------------------------------------------------------
// gnzm_controller
// Command sequencer: decodes the input beat, steps the store scan, and owns
// the result valid flag.
// ----------------------------------------------------------------------------
module gnzm_controller
    import gnzm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CMD_W-1:0]   s_command,
    output logic               m_valid,
    input  logic               m_ready,
    output gnzm_cmd_t          cmd,
    input  gnzm_status_t       status
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_RESP  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [STATUS_W-1:0] pend_code_reg, pend_code_next;
    logic                pend_match_reg, pend_match_next;
    logic                m_valid_reg, m_valid_next;
    logic                accept;
    logic                slot_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        pend_code_next  = pend_code_reg;
        pend_match_next = pend_match_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        cmd             = '0;
        cmd.out_code    = pend_code_reg;
        cmd.out_match   = pend_match_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pend_code_next  = STATUS_OK;
                    pend_match_next = 1'b0;
                    state_next      = ST_RESP;
                    unique case (s_command)
                        CMD_CLEAR: begin
                            cmd.count_clear = 1'b1;
                        end
                        CMD_LOAD: begin
                            if (status.full) begin
                                pend_code_next = STATUS_FULL;
                            end else begin
                                cmd.load_en = 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            if (status.empty) begin
                                pend_code_next = STATUS_NONE;
                            end else begin
                                cmd.scan_init = 1'b1;
                                state_next    = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the last read to pass the compare stage
                if (status.pipe_empty) begin
                    if (status.found) begin
                        cmd.mark        = 1'b1;
                        pend_code_next  = STATUS_OK;
                        pend_match_next = 1'b1;
                    end else begin
                        pend_code_next  = STATUS_NONE;
                        pend_match_next = 1'b0;
                    end
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            pend_code_reg  <= STATUS_OK;
            pend_match_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            pend_code_reg  <= pend_code_next;
            pend_match_reg <= pend_match_next;
        end
    end

endmodule
